/* rtl/idsv_pkg.sv */
// ----------------------------------------------------------------------------
// Date string validator package
// Field widths, character codes, status codes and the month length table.
// ----------------------------------------------------------------------------
package idsv_pkg;

    // Payload widths.
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 7;
    localparam int DAY_W    = 7;
    localparam int POS_W    = 4;
    localparam int DIGIT_W  = 4;
    localparam int MLEN_W   = 5;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [YEAR_W-1:0]   t_year;
    typedef logic [MONTH_W-1:0]  t_month;
    typedef logic [DAY_W-1:0]    t_day;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [DIGIT_W-1:0]  t_digit;
    typedef logic [MLEN_W-1:0]   t_mlen;

    // Status codes; the error codes are listed in order of priority.
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_LEN   = 3'd1;
    localparam t_status ST_HYPHEN    = 3'd2;
    localparam t_status ST_NON_DIGIT = 3'd3;
    localparam t_status ST_MONTH     = 3'd4;
    localparam t_status ST_DAY       = 3'd5;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    // String layout: YYYY-MM-DD.
    localparam t_pos POS_HYPHEN_A = 4'd4;
    localparam t_pos POS_HYPHEN_B = 4'd7;
    localparam t_pos POS_CENT     = 4'd2;
    localparam t_pos POS_UNIT     = 4'd3;
    localparam t_pos POS_MONTH    = 4'd5;
    localparam t_pos DATE_LEN     = 4'd10;
    localparam t_pos POS_SAT      = 4'd11;

    localparam t_month MONTH_MAX = 7'd12;

    // Length of a month in days, given whether the year is a leap year.
    function automatic t_mlen month_len(input t_month month, input logic leap);
        t_mlen len;
        case (month)
            7'd4, 7'd6, 7'd9, 7'd11: begin
                len = 5'd30;
            end
            7'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

/* rtl/idsv_if.sv */
// ----------------------------------------------------------------------------
// Date string validator channels
// Valid/ready channels for the character stream and for the results.
// ----------------------------------------------------------------------------

// Character channel: one byte of the string per item.
interface idsv_in_if;
    import idsv_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// Result channel: one item per string.
interface idsv_out_if;
    import idsv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [YEAR_W-1:0]   year_value;
    logic [MONTH_W-1:0]  month_value;
    logic [DAY_W-1:0]    day_value;

    modport source (output valid, output status, output year_value,
                    output month_value, output day_value, input ready);
    modport sink   (input valid, input status, input year_value,
                    input month_value, input day_value, output ready);
endinterface

/* rtl/iso_date_string_validator_core.sv */
// ----------------------------------------------------------------------------
// Date string validator core
// Checks a YYYY-MM-DD string fed one character per item and reports the
// status and the parsed year, month and day.
// ----------------------------------------------------------------------------
// Usage:
// The string enters on i_in, one character per item, with last_char set on
// its final character. Every character is taken into an input register;
// from there, once the result slot is free, it updates the running position,
// error flags and accumulators. A character with last_char set also loads the
// result register, which drives o_out, and clears the running state for the
// next string. The result passes through the input register and then the
// result register on its way to o_out.
// Throughput: one character per cycle while o_out is taken.
// Reset clears the input and result valid flags and all running state.
// When the receiver stalls, the result holds on o_out and the input register
// keeps one more character; i_in.ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module iso_date_string_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idsv_in_if.sink    i_in,
    idsv_out_if.source o_out
);
    import idsv_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // Running state for the string in progress.
    t_pos       r_pos;
    logic       r_hyph_err;
    logic       r_dig_err;
    t_year      r_year;
    t_month     r_month;
    t_day       r_day;
    logic       r_low_zero;
    logic [1:0] r_cent;

    // Result register.
    logic    r_res_valid;
    t_status r_res_status;
    t_year   r_res_year;
    t_month  r_res_month;
    t_day    r_res_day;

    // Next values.
    t_pos       n_pos;
    logic       n_hyph_err;
    logic       n_dig_err;
    t_year      n_year;
    t_month     n_month;
    t_day       n_day;
    logic       n_low_zero;
    logic [1:0] n_cent;
    t_status    n_status;

    logic   w_move;
    logic   w_step;
    logic   w_is_digit;
    t_digit w_digit;
    logic   w_leap;

    // Handshake: the input register moves on when the result slot is free.
    assign w_move     = !r_res_valid || o_out.ready;
    assign w_step     = r_in_valid && w_move;
    assign i_in.ready = !r_in_valid || w_move;

    // Character decode.
    assign w_is_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
    assign w_digit    = r_in_char[DIGIT_W-1:0];

    // Position, flags and accumulators after the held character.
    always_comb begin
        n_pos      = (r_pos < POS_SAT) ? r_pos + 4'd1 : POS_SAT;
        n_hyph_err = r_hyph_err;
        n_dig_err  = r_dig_err;
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_low_zero = r_low_zero;
        n_cent     = r_cent;
        if (r_pos < DATE_LEN) begin
            if (r_pos == POS_HYPHEN_A || r_pos == POS_HYPHEN_B) begin
                if (r_in_char != CH_HYPHEN) begin
                    n_hyph_err = 1'b1;
                end
            end else if (!w_is_digit) begin
                n_dig_err = 1'b1;
            end else if (r_pos < POS_HYPHEN_A) begin
                n_year = (r_year << 3) + (r_year << 1) + YEAR_W'(w_digit);
                // Track the century digits and whether the last two are zero.
                if (r_pos == POS_CENT) begin
                    n_cent     = r_year[1:0];
                    n_low_zero = (w_digit == '0);
                end else if (r_pos == POS_UNIT) begin
                    n_low_zero = r_low_zero && (w_digit == '0);
                end
            end else if (r_pos < POS_HYPHEN_B) begin
                n_month = (r_month << 3) + (r_month << 1) + MONTH_W'(w_digit);
            end else begin
                n_day = (r_day << 3) + (r_day << 1) + DAY_W'(w_digit);
            end
        end
    end

    // Gregorian leap year; only consulted when all four year digits are valid.
    assign w_leap = n_low_zero ? (n_cent == 2'd0) : (n_year[1:0] == 2'd0);

    // Status in order of priority.
    always_comb begin
        if (n_pos != DATE_LEN) begin
            n_status = ST_BAD_LEN;
        end else if (n_hyph_err) begin
            n_status = ST_HYPHEN;
        end else if (n_dig_err) begin
            n_status = ST_NON_DIGIT;
        end else if (n_month == '0 || n_month > MONTH_MAX) begin
            n_status = ST_MONTH;
        end else if (n_day == '0 || n_day > DAY_W'(month_len(n_month, w_leap))) begin
            n_status = ST_DAY;
        end else begin
            n_status = ST_OK;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.character;
            r_in_last <= i_in.last_char;
        end
    end

    // Running state; cleared after the last character of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hyph_err <= 1'b0;
            r_dig_err  <= 1'b0;
            r_year     <= '0;
            r_month    <= '0;
            r_day      <= '0;
            r_low_zero <= 1'b0;
            r_cent     <= '0;
        end else if (w_step) begin
            if (r_in_last) begin
                r_pos      <= '0;
                r_hyph_err <= 1'b0;
                r_dig_err  <= 1'b0;
                r_year     <= '0;
                r_month    <= '0;
                r_day      <= '0;
                r_low_zero <= 1'b0;
                r_cent     <= '0;
            end else begin
                r_pos      <= n_pos;
                r_hyph_err <= n_hyph_err;
                r_dig_err  <= n_dig_err;
                r_year     <= n_year;
                r_month    <= n_month;
                r_day      <= n_day;
                r_low_zero <= n_low_zero;
                r_cent     <= n_cent;
            end
        end
    end

    // Result register; values are zeroed for length, hyphen and digit errors.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_move) begin
            r_res_valid <= r_in_valid && r_in_last;
        end
        if (w_step && r_in_last) begin
            r_res_status <= n_status;
            if (n_status == ST_BAD_LEN || n_status == ST_HYPHEN
                    || n_status == ST_NON_DIGIT) begin
                r_res_year  <= '0;
                r_res_month <= '0;
                r_res_day   <= '0;
            end else begin
                r_res_year  <= n_year;
                r_res_month <= n_month;
                r_res_day   <= n_day;
            end
        end
    end

    assign o_out.valid       = r_res_valid;
    assign o_out.status      = r_res_status;
    assign o_out.year_value  = r_res_year;
    assign o_out.month_value = r_res_month;
    assign o_out.day_value   = r_res_day;

`ifndef SYNTHESIS
    // The last character of a string leaves the running state cleared.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_last) |=> (r_pos == '0 && !r_hyph_err && !r_dig_err))
        else $error("running state not cleared after the last character");

    // The position never runs past its saturation value.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("position beyond saturation");

    // A format error reports zero values.
    a_zero_on_format_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_BAD_LEN || o_out.status == ST_HYPHEN
            || o_out.status == ST_NON_DIGIT))
        |-> (o_out.year_value == '0 && o_out.month_value == '0
            && o_out.day_value == '0))
        else $error("nonzero values reported with a format error");

    // A passing date has a month and day in range.
    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OK)
        |-> (o_out.month_value != '0 && o_out.month_value <= MONTH_MAX
            && o_out.day_value != '0 && o_out.day_value <= DAY_W'(31)))
        else $error("passing date with month or day out of range");
`endif

endmodule
